// ===== rtl/srcm_pkg.sv =====
// ----------------------------------------------------------------------------
// srcm_pkg
// Shared types and constants for the sensor response curve mapper.
// ----------------------------------------------------------------------------
package srcm_pkg;

  localparam int FracBits = 16;
  localparam int XW       = FracBits + 1;          // value in [0, 1.0]
  localparam int DivCells = FracBits;              // quotient bits after the first
  localparam int SqrtCells = FracBits + 1;         // root bits
  localparam int RadW     = 2 * SqrtCells;         // radicand width
  localparam int SremW    = SqrtCells + 2;         // root remainder width

  localparam logic [XW-1:0] One = XW'(1) << FracBits;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SQUARE = 2'd1,
    CURVE_ROOT   = 2'd2,
    CURVE_SMOOTH = 2'd3
  } curve_t;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_FULL   = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    REG_CAL_GAIN      = 2'd0,
    REG_CURVE_SELECT  = 2'd1,
    REG_RANGE_FLOOR   = 2'd2,
    REG_RANGE_CEILING = 2'd3
  } reg_idx_t;

  typedef struct packed {
    curve_t curve;
    cls_t   cls;
  } side_t;

  typedef struct packed {
    logic [XW-1:0]       rem;
    logic [XW-1:0]       quo;
    logic [FracBits-1:0] den;
    side_t               side;
  } div_t;

  typedef struct packed {
    logic [RadW-1:0]      rad;
    logic [SremW-1:0]     rem;
    logic [SqrtCells-1:0] root;
    logic [XW-1:0]        m;
    side_t                side;
  } sqrt_t;

endpackage

// ===== rtl/srcm_sample_if.sv =====
// ----------------------------------------------------------------------------
// srcm_sample_if
// Input stream channel: one signed Q1.15 sensor sample per transfer.
// ----------------------------------------------------------------------------
interface srcm_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sensor_sample;

  modport source (output valid, output sensor_sample, input ready);
  modport sink   (input valid, input sensor_sample, output ready);
endinterface

// ===== rtl/srcm_cc_if.sv =====
// ----------------------------------------------------------------------------
// srcm_cc_if
// Output stream channel: one 7-bit controller value per transfer.
// ----------------------------------------------------------------------------
interface srcm_cc_if;
  logic       valid;
  logic       ready;
  logic [6:0] cc_value;

  modport source (output valid, output cc_value, input ready);
  modport sink   (input valid, input cc_value, output ready);
endinterface

// ===== rtl/srcm_div_cell.sv =====
// ----------------------------------------------------------------------------
// srcm_div_cell
// One restoring division step: shift, compare, subtract, emit a quotient bit.
// ----------------------------------------------------------------------------
module srcm_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  srcm_pkg::div_t in_data,
  output logic          out_valid,
  output srcm_pkg::div_t out_data
);
  import srcm_pkg::*;

  logic [XW:0] trial;
  logic        take;

  assign trial = {in_data.rem, 1'b0};
  assign take  = trial >= {2'b00, in_data.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rem  <= take ? XW'(trial - {2'b00, in_data.den}) : XW'(trial);
      out_data.quo  <= {in_data.quo[XW-2:0], take};
      out_data.den  <= in_data.den;
      out_data.side <= in_data.side;
    end
  end
endmodule

// ===== rtl/srcm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// srcm_sqrt_cell
// One digit-by-digit square root step: bring down two bits, emit a root bit.
// ----------------------------------------------------------------------------
module srcm_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  srcm_pkg::sqrt_t in_data,
  output logic           out_valid,
  output srcm_pkg::sqrt_t out_data
);
  import srcm_pkg::*;

  logic [SremW-1:0] rem2;
  logic [SremW-1:0] trial;
  logic             take;

  assign rem2  = {in_data.rem[SremW-3:0], in_data.rad[RadW-1 -: 2]};
  assign trial = {in_data.root, 2'b01};
  assign take  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rad  <= {in_data.rad[RadW-3:0], 2'b00};
      out_data.rem  <= take ? rem2 - trial : rem2;
      out_data.root <= {in_data.root[SqrtCells-2:0], take};
      out_data.m    <= in_data.m;
      out_data.side <= in_data.side;
    end
  end
endmodule

// ===== rtl/sensor_response_curve_mapper_core.sv =====
// ----------------------------------------------------------------------------
// sensor_response_curve_mapper_core
// Sensor sample to MIDI controller value, trimmed and shaped by a curve.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 16 divider cells, 17 root cells, 3 multiply/select
//   stages and the output register, from input transfer to result valid.
// Throughput: one sample per cycle; the whole pipe advances as one and holds
//   only when the output register is full and not taken.
// Reset (synchronous, rst high): clears all valid bits, loads the register
//   defaults (unity gain, linear curve, full trim range).
// ----------------------------------------------------------------------------
module sensor_response_curve_mapper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  srcm_sample_if.sink sample_ch,
  srcm_cc_if.source   cc_ch
);
  import srcm_pkg::*;

  // Configuration registers
  logic [15:0] cal_gain;
  curve_t      curve_select;
  logic [15:0] range_floor;
  logic [15:0] range_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_gain      <= 16'd4096;
      curve_select  <= CURVE_LINEAR;
      range_floor   <= 16'd0;
      range_ceiling <= 16'hFFFF;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CAL_GAIN:      cal_gain      <= cfg_data;
        REG_CURVE_SELECT:  curve_select  <= curve_t'(cfg_data[1:0]);
        REG_RANGE_FLOOR:   range_floor   <= cfg_data;
        REG_RANGE_CEILING: range_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move everything when the output slot is free or drains.
  logic en;
  assign en = !cc_ch.valid || cc_ch.ready;
  assign sample_ch.ready = en;

  // Stage 0: gain multiply, clamp to [0, 1.0]
  logic [31:0]   prod;
  logic [20:0]   x_wide;
  logic [XW-1:0] x_comb;
  logic          s0_valid;
  logic [XW-1:0] s0_x;

  assign prod   = {16'd0, sample_ch.sensor_sample} * {16'd0, cal_gain};
  assign x_wide = prod[31:11];

  always_comb begin
    if (sample_ch.sensor_sample[15]) begin
      x_comb = '0;
    end else if (x_wide > {4'd0, One}) begin
      x_comb = One;
    end else begin
      x_comb = x_wide[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x <= x_comb;
    end
  end

  // Stage 1: trim classification and the top quotient bit
  cls_t          cls_comb;
  logic [XW-1:0] num;
  logic [15:0]   den;
  logic          q_top;
  div_t          div_in;
  logic          div_in_valid;

  assign num   = s0_x - {1'b0, range_floor};
  assign den   = range_ceiling - range_floor;
  assign q_top = num >= {1'b0, den};

  always_comb begin
    if (s0_x < {1'b0, range_floor}) begin
      cls_comb = CLS_ZERO;
    end else if (s0_x > {1'b0, range_ceiling}) begin
      cls_comb = CLS_FULL;
    end else if (range_ceiling == range_floor) begin
      cls_comb = CLS_ZERO;
    end else begin
      cls_comb = CLS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in_valid <= 1'b0;
    end else if (en) begin
      div_in_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_in.rem        <= q_top ? num - {1'b0, den} : num;
      div_in.quo        <= {{(XW-1){1'b0}}, q_top};
      div_in.den        <= den;
      div_in.side.curve <= curve_select;
      div_in.side.cls   <= cls_comb;
    end
  end

  // Divider chain: one quotient bit per cell
  div_t div_d [DivCells+1];
  logic div_v [DivCells+1];

  assign div_d[0] = div_in;
  assign div_v[0] = div_in_valid;

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    srcm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_v[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  // Root chain: radicand is m with FracBits zero bits below it
  sqrt_t sq_d [SqrtCells+1];
  logic  sq_v [SqrtCells+1];

  assign sq_d[0].rad  = {{(RadW-XW-FracBits){1'b0}}, div_d[DivCells].quo, {FracBits{1'b0}}};
  assign sq_d[0].rem  = '0;
  assign sq_d[0].root = '0;
  assign sq_d[0].m    = div_d[DivCells].quo;
  assign sq_d[0].side = div_d[DivCells].side;
  assign sq_v[0]      = div_v[DivCells];

  for (genvar j = 0; j < SqrtCells; j++) begin : g_sqrt
    srcm_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v[j]),
      .in_data   (sq_d[j]),
      .out_valid (sq_v[j+1]),
      .out_data  (sq_d[j+1])
    );
  end

  // M1: square of m
  logic          m1_valid;
  logic [2*XW-1:0] m1_sq;
  logic [XW-1:0] m1_m;
  logic [XW-1:0] m1_root;
  side_t         m1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= sq_v[SqrtCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sq   <= sq_d[SqrtCells].m * sq_d[SqrtCells].m;
      m1_m    <= sq_d[SqrtCells].m;
      m1_root <= sq_d[SqrtCells].root;
      m1_side <= sq_d[SqrtCells].side;
    end
  end

  // M2: smoothstep product q * (3 - 2m)
  logic [XW-1:0]   q;
  logic [XW:0]     k;
  logic            m2_valid;
  logic [2*XW:0]   m2_pr;
  logic [XW-1:0]   m2_q;
  logic [XW-1:0]   m2_m;
  logic [XW-1:0]   m2_root;
  side_t           m2_side;

  assign q = m1_sq[FracBits +: XW];
  assign k = (XW+1)'(3 * (1 << FracBits)) - {m1_m, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_pr   <= {{(XW+1){1'b0}}, q} * {{XW{1'b0}}, k};
      m2_q    <= q;
      m2_m    <= m1_m;
      m2_root <= m1_root;
      m2_side <= m1_side;
    end
  end

  // M3: pick the curve, apply trim overrides, clamp to 1.0
  logic [XW-1:0] y_comb;
  logic [XW+1:0] smooth;
  logic          m3_valid;
  logic [XW-1:0] m3_y;

  assign smooth = m2_pr[FracBits +: (XW+2)];

  always_comb begin
    case (m2_side.curve)
      CURVE_LINEAR: y_comb = m2_m;
      CURVE_SQUARE: y_comb = m2_q;
      CURVE_ROOT:   y_comb = m2_root;
      CURVE_SMOOTH: y_comb = (smooth > {2'b00, One}) ? One : smooth[XW-1:0];
      default:      y_comb = m2_m;
    endcase
    if (y_comb > One) begin
      y_comb = One;
    end
    case (m2_side.cls)
      CLS_ZERO: y_comb = '0;
      CLS_FULL: y_comb = One;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (en) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_y <= y_comb;
    end
  end

  // Output register: scale by 127 and truncate
  logic [XW+6:0] scaled;
  logic [7:0]    cc_wide;

  assign scaled  = {7'd0, m3_y} * (XW+7)'(127);
  assign cc_wide = scaled[FracBits +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      cc_ch.valid <= 1'b0;
    end else if (en) begin
      cc_ch.valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_ch.cc_value <= (cc_wide > 8'd127) ? 7'd127 : cc_wide[6:0];
    end
  end
endmodule
